// ===== rtl/core/aes128_block_cipher_defines.svh =====
// ---------------------------------------------------------------------------
// AES-128 block cipher assertion macros
// Shared concurrent assertion forms for the cipher core.
// ---------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on the core clock, off during reset.
`define AES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the core clock, off during reset.
`define AES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/aes_pkg.sv =====
// ---------------------------------------------------------------------------
// AES-128 package
// Types, S-box tables and round functions shared by the cipher core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aes_pkg;

    localparam int ROUNDS  = 10;
    // input register, key expansion stages, cipher round stages
    localparam int LATENCY = 1 + 2 * ROUNDS;

    typedef struct packed {
        logic [63:0] block_hi;
        logic [63:0] block_lo;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
    } t_in;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } t_out;

    // key expansion pipe: block held, cipher key kept, round key advanced
    typedef struct packed {
        logic         valid;
        logic         decrypt;
        logic [127:0] block;
        logic [127:0] key0;
        logic [127:0] rkey;
    } t_kx;

    // cipher round pipe: state and the round key last applied
    typedef struct packed {
        logic         valid;
        logic         decrypt;
        logic [127:0] state;
        logic [127:0] rkey;
    } t_rs;

    typedef logic [7:0] t_box [256];

    localparam t_box FWD_BOX = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    function automatic t_box f_invert(input t_box fwd);
        t_box inv;
        for (int i = 0; i < 256; i++) begin
            inv[fwd[i]] = 8'(i);
        end
        return inv;
    endfunction

    localparam t_box INV_BOX = f_invert(FWD_BOX);

    function automatic logic [7:0] f_xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] f_rcon(input logic [3:0] r);
        logic [7:0] rc;
        unique case (r)
            4'd1:    rc = 8'h01;
            4'd2:    rc = 8'h02;
            4'd3:    rc = 8'h04;
            4'd4:    rc = 8'h08;
            4'd5:    rc = 8'h10;
            4'd6:    rc = 8'h20;
            4'd7:    rc = 8'h40;
            4'd8:    rc = 8'h80;
            4'd9:    rc = 8'h1B;
            4'd10:   rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // rotate, substitute and add the round constant
    function automatic logic [31:0] f_core(input logic [31:0] w, input logic [3:0] r);
        logic [31:0] t;
        t = {w[23:0], w[31:24]};
        return {FWD_BOX[t[31:24]] ^ f_rcon(r), FWD_BOX[t[23:16]],
                FWD_BOX[t[15:8]], FWD_BOX[t[7:0]]};
    endfunction

    // round key r from round key r-1
    function automatic logic [127:0] f_key_fwd(input logic [127:0] k, input logic [3:0] r);
        logic [31:0] n0, n1, n2, n3;
        n0 = k[127:96] ^ f_core(k[31:0], r);
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // round key r-1 from round key r
    function automatic logic [127:0] f_key_inv(input logic [127:0] k, input logic [3:0] r);
        logic [31:0] p0, p1, p2, p3;
        p3 = k[31:0] ^ k[63:32];
        p2 = k[63:32] ^ k[95:64];
        p1 = k[95:64] ^ k[127:96];
        p0 = k[127:96] ^ f_core(p3, r);
        return {p0, p1, p2, p3};
    endfunction

    function automatic logic [127:0] f_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        int src, dst;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                dst = r + 4 * c;
                src = r + 4 * ((c + r) & 3);
                t[127 - 8 * dst -: 8] = FWD_BOX[s[127 - 8 * src -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] f_inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        int src, dst;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = r + 4 * c;
                dst = r + 4 * ((c + r) & 3);
                t[127 - 8 * dst -: 8] = INV_BOX[s[127 - 8 * src -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] f_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 8] = f_xtime(a0) ^ f_xtime(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32 * c -: 8] = a0 ^ f_xtime(a1) ^ f_xtime(a2) ^ a2 ^ a3;
            t[111 - 32 * c -: 8] = a0 ^ a1 ^ f_xtime(a2) ^ f_xtime(a3) ^ a3;
            t[103 - 32 * c -: 8] = f_xtime(a0) ^ a0 ^ a1 ^ a2 ^ f_xtime(a3);
        end
        return t;
    endfunction

    function automatic logic [31:0] f_inv_col(input logic [31:0] col);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [7:0] x2, x4, x8;
        for (int i = 0; i < 4; i++) begin
            a[i]  = col[31 - 8 * i -: 8];
            x2    = f_xtime(a[i]);
            x4    = f_xtime(x2);
            x8    = f_xtime(x4);
            m9[i] = x8 ^ a[i];
            mb[i] = x8 ^ x2 ^ a[i];
            md[i] = x8 ^ x4 ^ a[i];
            me[i] = x8 ^ x4 ^ x2;
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    function automatic logic [127:0] f_inv_mix(input logic [127:0] s);
        return {f_inv_col(s[127:96]), f_inv_col(s[95:64]),
                f_inv_col(s[63:32]), f_inv_col(s[31:0])};
    endfunction

endpackage

// ===== rtl/core/aes_kexp_stage.sv =====
// ---------------------------------------------------------------------------
// AES key expansion stage
// Advance the round key by one step; hold block and cipher key alongside.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_kexp_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [3:0]    i_round,
    input  aes_pkg::t_kx  i_kx,
    output aes_pkg::t_kx  o_kx
);

    logic         r_valid;
    aes_pkg::t_kx r_kx;
    aes_pkg::t_kx n_kx;

    always_comb begin
        n_kx      = i_kx;
        n_kx.rkey = aes_pkg::f_key_fwd(i_kx.rkey, i_round);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_kx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_kx.valid) begin
            r_kx <= n_kx;
        end
    end

    always_comb begin
        o_kx       = r_kx;
        o_kx.valid = r_valid;
    end

endmodule

// ===== rtl/core/aes_rnd_stage.sv =====
// ---------------------------------------------------------------------------
// AES cipher round stage
// One forward or inverse round, with its round key derived in place.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_rnd_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [3:0]    i_round,
    input  aes_pkg::t_rs  i_rs,
    output aes_pkg::t_rs  o_rs
);

    localparam logic [3:0] LAST = 4'(aes_pkg::ROUNDS);

    logic         r_valid;
    aes_pkg::t_rs r_rs;
    aes_pkg::t_rs n_rs;
    logic [127:0] w_key;
    logic [127:0] w_mid;

    always_comb begin
        n_rs = i_rs;
        if (!i_rs.decrypt) begin
            w_key = aes_pkg::f_key_fwd(i_rs.rkey, i_round);
            w_mid = aes_pkg::f_sub_shift(i_rs.state);
            if (i_round != LAST) begin
                w_mid = aes_pkg::f_mix(w_mid);
            end
            n_rs.state = w_mid ^ w_key;
        end else begin
            // walk the schedule backwards, key for round LAST - i_round
            w_key = aes_pkg::f_key_inv(i_rs.rkey, LAST + 4'd1 - i_round);
            w_mid = aes_pkg::f_inv_sub_shift(i_rs.state) ^ w_key;
            if (i_round != LAST) begin
                w_mid = aes_pkg::f_inv_mix(w_mid);
            end
            n_rs.state = w_mid;
        end
        n_rs.rkey = w_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_rs.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rs.valid) begin
            r_rs <= n_rs;
        end
    end

    always_comb begin
        o_rs       = r_rs;
        o_rs.valid = r_valid;
    end

endmodule

// ===== rtl/core/aes128_block_cipher.sv =====
// ---------------------------------------------------------------------------
// AES-128 block cipher
// Pipelined AES-128 encrypt/decrypt, fresh key schedule for every block.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  ----------------------
//  command   in         start & !busy                i_blk  (block, key)
//  config    in         i_cfg_valid & o_cfg_ready    i_cfg_data (decrypt)
//  result    out        o_res_valid, one-cycle pulse o_res  (result block)
//
//  One block may be transferred every cycle; each result passes through one
//  input register, ten key expansion stages (the decrypt path needs the
//  last round key first) and ten round stages after its command transfer.
//  busy is high only during reset; there is no clearing pass.
//  The result strobe cannot be stalled, so the pipe never holds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aes128_block_cipher_defines.svh"

module aes128_block_cipher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  aes_pkg::t_in  i_blk,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data,
    output logic          o_res_valid,
    output aes_pkg::t_out o_res
);

    localparam int R = aes_pkg::ROUNDS;

    logic         r_mode;
    logic         r_in_valid;
    aes_pkg::t_kx r_in;
    logic         w_take;
    aes_pkg::t_kx w_kx [R + 1];
    aes_pkg::t_rs w_rs [R + 1];

    // Block nothing but reset; config lands in the mode register in the following cycle.
    assign busy        = !i_rst_n;
    assign o_cfg_ready = 1'b1;
    assign w_take      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // Capture the command transfer with the mode it runs under.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.valid   <= 1'b1;
            r_in.decrypt <= r_mode;
            r_in.block   <= {i_blk.block_hi, i_blk.block_lo};
            r_in.key0    <= {i_blk.key_hi, i_blk.key_lo};
            r_in.rkey    <= {i_blk.key_hi, i_blk.key_lo};
        end
    end

    always_comb begin
        w_kx[0]       = r_in;
        w_kx[0].valid = r_in_valid;
    end

    // Advance the key schedule to the last round key.
    for (genvar g = 0; g < R; g++) begin : g_kexp
        aes_kexp_stage u_kexp (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_round (4'(g + 1)),
            .i_kx    (w_kx[g]),
            .o_kx    (w_kx[g + 1])
        );
    end

    // Initial key add: encrypt starts from the cipher key and walks forward,
    // decrypt starts from the last round key and walks back.
    always_comb begin
        w_rs[0].valid   = w_kx[R].valid;
        w_rs[0].decrypt = w_kx[R].decrypt;
        w_rs[0].rkey    = w_kx[R].decrypt ? w_kx[R].rkey : w_kx[R].key0;
        w_rs[0].state   = w_kx[R].block ^ w_rs[0].rkey;
    end

    for (genvar g = 0; g < R; g++) begin : g_rnd
        aes_rnd_stage u_rnd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_round (4'(g + 1)),
            .i_rs    (w_rs[g]),
            .o_rs    (w_rs[g + 1])
        );
    end

    assign o_res_valid     = w_rs[R].valid;
    assign o_res.result_hi = w_rs[R].state[127:64];
    assign o_res.result_lo = w_rs[R].state[63:0];

    `AES_ASSERT_IMP(a_res_has_cmd, o_res_valid, $past(start && !busy, aes_pkg::LATENCY), "result without matching command transfer")
    `AES_ASSERT_IMP(a_reset_drains, !$past(i_rst_n), !o_res_valid, "result strobe right after reset")
    `AES_ASSERT_NXT(a_cfg_lands, i_cfg_valid && o_cfg_ready, r_mode == $past(i_cfg_data), "config transfer not taken")

endmodule

// ===== dv/tb_aes128_block_cipher.sv =====
// ---------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives blocks and keys in both modes, predicts each result with a
// behavioural cipher of its own and checks every result strobe in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aes128_block_cipher;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    aes_pkg::t_in  i_blk;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic          i_cfg_data;
    logic          o_res_valid;
    aes_pkg::t_out o_res;

    // predictor copy of the mode register
    logic          mode_decrypt;
    // cipher outputs still owed by the block, oldest first
    aes_pkg::t_out cipher_q[$];
    int            fail_count;

    logic [7:0] sbox [256];
    logic [7:0] sbox_inv [256];

    aes128_block_cipher u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_blk      (i_blk),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Build the substitution table from its algebraic definition: the
    // multiplicative inverse in GF(2^8) followed by the affine map with 0x63.
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
        end
        return acc;
    endfunction

    task automatic build_boxes();
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++) begin
                if (gmul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
            end
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox[x] = s;
            sbox_inv[s] = 8'(x);
        end
    endtask

    function automatic aes_pkg::t_out aes_cipher(input aes_pkg::t_in blk, input logic dec);
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] rk [176];
        logic [7:0] t [4];
        logic [7:0] col [4];
        logic [7:0] rc;
        logic [7:0] f;
        logic [7:0] m [4];
        int other;
        int rd;
        aes_pkg::t_out res;
        for (int i = 0; i < 8; i++) begin
            st[i]     = blk.block_hi[63 - 8 * i -: 8];
            st[8 + i] = blk.block_lo[63 - 8 * i -: 8];
            rk[i]     = blk.key_hi[63 - 8 * i -: 8];
            rk[8 + i] = blk.key_lo[63 - 8 * i -: 8];
        end
        rc = 8'h01;
        for (int w = 4; w < 44; w++) begin
            for (int j = 0; j < 4; j++) t[j] = rk[(w - 1) * 4 + j];
            if ((w & 3) == 0) begin
                f = t[0];
                t[0] = sbox[t[1]] ^ rc;
                t[1] = sbox[t[2]];
                t[2] = sbox[t[3]];
                t[3] = sbox[f];
                rc = gmul(rc, 8'h02);
            end
            for (int j = 0; j < 4; j++) rk[w * 4 + j] = rk[(w - 4) * 4 + j] ^ t[j];
        end
        if (dec) begin
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        end else begin
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[(dec ? 160 : 0) + i];
        for (int n = 1; n <= 10; n++) begin
            rd = dec ? 10 - n : n;
            // substitute and shift rows
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    other = r + 4 * ((c + r) & 3);
                    if (dec) tmp[other] = sbox_inv[st[r + 4 * c]];
                    else tmp[r + 4 * c] = sbox[st[other]];
                end
            end
            st = tmp;
            // inverse cipher adds the key before unmixing
            if (dec) for (int i = 0; i < 16; i++) st[i] ^= rk[rd * 16 + i];
            if (n != 10) begin
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) col[r] = st[4 * c + r];
                    for (int r = 0; r < 4; r++) begin
                        st[4 * c + r] = gmul(m[(4 - r) & 3], col[0])
                            ^ gmul(m[(5 - r) & 3], col[1])
                            ^ gmul(m[(6 - r) & 3], col[2])
                            ^ gmul(m[(7 - r) & 3], col[3]);
                    end
                end
            end
            if (!dec) for (int i = 0; i < 16; i++) st[i] ^= rk[rd * 16 + i];
        end
        for (int i = 0; i < 8; i++) begin
            res.result_hi[63 - 8 * i -: 8] = st[i];
            res.result_lo[63 - 8 * i -: 8] = st[8 + i];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        // bias towards all-zero and all-one halves now and then
        case ($urandom_range(0, 15))
            0: v = '0;
            1: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    // Mostly short gaps, an occasional long one, and runs with none.
    // Drop start for the length of the gap.
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 9);
        if (n < 5) n = 0;
        else if (n < 9) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Send one block: hold start until the transfer, then queue the result.
    // start stays high for a following block; whoever idles next drops it.
    task automatic send_block(input aes_pkg::t_in blk, input bit gaps);
        if (gaps) idle_gap();
        start <= 1'b1;
        i_blk <= blk;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cipher_q.push_back(aes_cipher(blk, mode_decrypt));
        @(negedge i_clk);
    endtask

    // Let the pipe drain, then write the mode register.
    task automatic set_mode(input logic dec);
        start <= 1'b0;
        while (cipher_q.size() != 0) @(negedge i_clk);
        repeat (aes_pkg::LATENCY + 4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= dec;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mode_decrypt = dec;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
    endtask

    // Known-answer vectors from the standard, field extremes and six random blocks in each mode.
    task automatic test_directed();
        aes_pkg::t_in blk;
        blk = {64'h0011223344556677, 64'h8899aabbccddeeff,
               64'h0001020304050607, 64'h08090a0b0c0d0e0f};
        send_block(blk, 1'b0);
        blk = {64'h3243f6a8885a308d, 64'h313198a2e0370734,
               64'h2b7e151628aed2a6, 64'habf7158809cf4f3c};
        send_block(blk, 1'b0);
        send_block('0, 1'b0);
        send_block('1, 1'b0);
        send_block({128'h0, {128{1'b1}}}, 1'b0);
        send_block({{128{1'b1}}, 128'h0}, 1'b0);
        for (int i = 0; i < 6; i++) begin
            send_block({rand64(), rand64(), rand64(), rand64()}, 1'b0);
        end
        set_mode(1'b1);
        blk = {64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a,
               64'h0001020304050607, 64'h08090a0b0c0d0e0f};
        send_block(blk, 1'b0);
        send_block('0, 1'b0);
        send_block('1, 1'b0);
        send_block({128'h0, {128{1'b1}}}, 1'b0);
        send_block({{128{1'b1}}, 128'h0}, 1'b0);
        for (int i = 0; i < 6; i++) begin
            send_block({rand64(), rand64(), rand64(), rand64()}, 1'b0);
        end
    endtask

    // Random blocks and keys, mode switched between bursts.
    task automatic test_random();
        int burst;
        for (int b = 0; b < 15; b++) begin
            set_mode(1'($urandom_range(0, 1)));
            burst = $urandom_range(80, 120);
            for (int i = 0; i < burst; i++) begin
                send_block({rand64(), rand64(), rand64(), rand64()}, (b % 4) != 3);
            end
        end
        set_mode(1'b0);
        for (int i = 0; i < 40; i++) begin
            send_block({rand64(), rand64(), rand64(), rand64()}, 1'b1);
        end
    endtask

    // Compare every result strobe with the oldest expected block.
    always @(posedge i_clk) begin
        aes_pkg::t_out exp_res;
        if (i_rst_n && o_res_valid) begin
            if (cipher_q.size() == 0) begin
                $error("result_hi: unexpected result %h", o_res.result_hi);
                fail_count++;
            end else begin
                exp_res = cipher_q.pop_front();
                if (o_res.result_hi !== exp_res.result_hi) begin
                    $error("result_hi: expected %h actual %h",
                           exp_res.result_hi, o_res.result_hi);
                    fail_count++;
                end
                if (o_res.result_lo !== exp_res.result_lo) begin
                    $error("result_lo: expected %h actual %h",
                           exp_res.result_lo, o_res.result_lo);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_blk        = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = 1'b0;
        mode_decrypt = 1'b0;
        fail_count   = 0;
        build_boxes();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random();
        start <= 1'b0;
        while (cipher_q.size() != 0) @(negedge i_clk);
        repeat (aes_pkg::LATENCY + 4) @(negedge i_clk);
        if (fail_count == 0 && cipher_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
